@@ sv/pal_pkg.sv @@
// Package for the polyline arc length point block: sizes, codes and shared types.
// Used by pal_ctrl, pal_dp and the top level; depends on nothing.
`timescale 1ns / 1ps
package pal_pkg;

    localparam int MaxPoints = 1024;
    localparam int IdxW = $clog2(MaxPoints);
    localparam int CntW = IdxW + 1;
    localparam int CfgAddrW = 2;

    localparam logic CmdWrite = 1'b0;
    localparam logic CmdQuery = 1'b1;

    localparam logic [CfgAddrW-1:0] RegPointCount = 2'd0;
    localparam logic [CfgAddrW-1:0] RegTotalLength = 2'd1;
    localparam logic [CfgAddrW-1:0] RegMinRender = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_SRCH,
        ST_CMP,
        ST_RDSEG,
        ST_DIV,
        ST_RD0,
        ST_RD1,
        ST_LERP,
        ST_OUT
    } pal_state_t;

    // Read source for the memory address in the datapath.
    typedef enum logic [2:0] {
        RA_ZERO,
        RA_LAST,
        RA_MID,
        RA_SEG,
        RA_SEGM1,
        RA_SEGP1
    } pal_raddr_t;

    typedef struct packed {
        logic       load_query;
        logic       start_search;
        logic       search_step;
        pal_raddr_t raddr;
        logic       take_start;
        logic       take_end;
        logic       div_step;
        logic       take_p0;
        logic       take_p1;
        logic       lerp;
        logic       out_load;
    } pal_cmd_t;

    typedef struct packed {
        logic invisible;
        logic empty;
        logic first_only;
        logic use_last;
        logic search_done;
        logic div_done;
    } pal_status_t;

endpackage

@@ sv/pal_ram.sv @@
// Generic simple dual-port RAM with one write and one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
module pal_ram #(
    parameter int Width = 32,
    parameter int Depth = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/pal_ctrl.sv @@
// Controller state machine of the polyline arc length point block.
// Depends on pal_pkg.
`timescale 1ns / 1ps
module pal_ctrl
    import pal_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_go,
    input  logic        out_valid,
    input  logic        out_taken,
    input  pal_status_t status,
    output pal_cmd_t    cmd,
    output logic        busy
);

    pal_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_go) state_next = ST_MUL;
            ST_MUL:
            begin
                if (status.invisible || status.empty) state_next = ST_OUT;
                else if (status.first_only || status.use_last) state_next = ST_RD0;
                else state_next = ST_SRCH;
            end
            ST_SRCH:  state_next = status.search_done ? ST_RDSEG : ST_CMP;
            ST_CMP:   state_next = ST_SRCH;
            ST_RDSEG: state_next = ST_DIV;
            ST_DIV:   if (status.div_done) state_next = ST_RD0;
            ST_RD0:   state_next = ST_RD1;
            ST_RD1:   state_next = ST_LERP;
            ST_LERP:  state_next = ST_OUT;
            ST_OUT:   if (!out_valid || out_taken) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Command outputs.
    always_comb
    begin
        cmd = '0;
        cmd.raddr = RA_ZERO;
        busy = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load_query = in_go;
            end
            ST_MUL:
            begin
                // Read the end vertex now when no search follows.
                cmd.start_search = 1'b1;
                cmd.raddr = status.use_last ? RA_LAST : RA_ZERO;
            end
            ST_SRCH:
            begin
                // Present the probe address; the compare follows in the next cycle.
                cmd.raddr = status.search_done ? RA_SEGM1 : RA_MID;
            end
            ST_CMP:
            begin
                cmd.search_step = 1'b1;
                cmd.raddr = RA_MID;
            end
            ST_RDSEG:
            begin
                cmd.raddr = RA_SEG;
                cmd.take_start = 1'b1;
            end
            ST_DIV:
            begin
                cmd.take_end = 1'b1;
                cmd.div_step = 1'b1;
                cmd.raddr = status.use_last ? RA_LAST :
                            (status.first_only ? RA_ZERO : RA_SEG);
            end
            ST_RD0:
            begin
                cmd.raddr = (status.use_last) ? RA_LAST :
                            (status.first_only ? RA_ZERO : RA_SEGP1);
                cmd.take_p0 = 1'b1;
            end
            ST_RD1:
            begin
                // Hold the far vertex on the read port for the interpolation.
                cmd.take_p1 = 1'b1;
                cmd.raddr = RA_SEGP1;
            end
            ST_LERP:
            begin
                cmd.lerp = 1'b1;
            end
            ST_OUT:
            begin
                cmd.out_load = !out_valid || out_taken;
            end
            default: ;
        endcase
    end

endmodule

@@ sv/pal_dp.sv @@
// Datapath: vertex tables, search, serial divider and interpolation.
// Depends on pal_pkg and pal_ram.
`timescale 1ns / 1ps
module pal_dp
    import pal_pkg::*;
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [IdxW-1:0]    wr_idx,
    input  logic [31:0]        wr_x,
    input  logic [31:0]        wr_y,
    input  logic [31:0]        wr_d,
    input  logic signed [31:0] q_t,
    input  logic [CntW-1:0]    point_count,
    input  logic [31:0]        total_length,
    input  logic signed [31:0] min_render,
    input  pal_cmd_t           cmd,
    output pal_status_t        status,
    output logic [31:0]        res_x,
    output logic [31:0]        res_y,
    output logic               res_vis
);

    logic [IdxW-1:0] raddr;
    logic [31:0] rx, ry, rd;
    logic signed [31:0] t_reg;
    logic [CntW-1:0] n_reg;
    logic [31:0] target_reg;
    logic [63:0] prod;
    logic inv_reg, empty_reg, first_reg, last_reg;
    logic [IdxW-1:0] lo_reg, hi_reg, mid;
    logic [31:0] start_reg;
    logic [32:0] len_reg, rem_reg;
    logic [16:0] w_reg;
    logic [4:0] dcnt_reg;
    logic ddone_reg;
    logic [31:0] x0_reg, y0_reg;
    logic [31:0] ox_reg, oy_reg;
    logic [CntW-1:0] nclamp;
    logic [IdxW-1:0] last_idx;

    pal_ram #(.Width(32), .Depth(MaxPoints)) u_ram_x (
        .clk(clk), .we(wr_en), .waddr(wr_idx), .wdata(wr_x), .raddr(raddr), .rdata(rx));
    pal_ram #(.Width(32), .Depth(MaxPoints)) u_ram_y (
        .clk(clk), .we(wr_en), .waddr(wr_idx), .wdata(wr_y), .raddr(raddr), .rdata(ry));
    pal_ram #(.Width(32), .Depth(MaxPoints)) u_ram_d (
        .clk(clk), .we(wr_en), .waddr(wr_idx), .wdata(wr_d), .raddr(raddr), .rdata(rd));

    assign nclamp = (point_count > CntW'(MaxPoints)) ? CntW'(MaxPoints) : point_count;
    assign last_idx = IdxW'(n_reg - 1'b1);
    assign mid = IdxW'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);
    assign prod = 64'(unsigned'(t_reg)) * 64'(total_length);

    // Memory address select.
    always_comb
    begin
        case (cmd.raddr)
            RA_ZERO:  raddr = '0;
            RA_LAST:  raddr = last_idx;
            RA_MID:   raddr = mid;
            RA_SEG:   raddr = lo_reg;
            RA_SEGM1: raddr = lo_reg - 1'b1;
            RA_SEGP1: raddr = lo_reg + 1'b1;
            default:  raddr = '0;
        endcase
    end

    // Query setup, classification and binary search steps.
    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
        begin
            t_reg <= q_t;
            n_reg <= nclamp;
            inv_reg <= (q_t < min_render);
            empty_reg <= (nclamp == '0);
        end
        if (cmd.start_search)
        begin
            target_reg <= prod[47:16];
            first_reg <= (n_reg < 2) || (total_length == 0) || (t_reg <= 0)
                         || (prod[63:16] == '0);
            last_reg <= !((n_reg < 2) || (total_length == 0) || (t_reg <= 0))
                        && (prod[63:16] >= {16'd0, total_length});
            lo_reg <= '0;
            hi_reg <= IdxW'(n_reg - 2'd2);
        end
        else if (cmd.search_step && (lo_reg < hi_reg))
        begin
            if (rd < target_reg) lo_reg <= mid + 1'b1;
            else hi_reg <= mid;
        end
    end

    // Segment bounds and the restoring divider for the Q1.16 weight.
    always_ff @(posedge clk)
    begin
        if (cmd.take_start)
        begin
            start_reg <= (lo_reg == '0) ? 32'd0 : rd;
        end
        if (cmd.take_end && dcnt_reg == 5'd0 && !ddone_reg)
        begin
            len_reg <= {1'b0, rd - start_reg};
            if (rd <= start_reg) rem_reg <= '0;
            else if (target_reg <= start_reg) rem_reg <= '0;
            else if (target_reg - start_reg > rd - start_reg) rem_reg <= {1'b0, rd - start_reg};
            else rem_reg <= {1'b0, target_reg - start_reg};
            w_reg <= '0;
            // A segment of no length keeps a zero weight and skips the divide.
            dcnt_reg <= (rd <= start_reg) ? 5'd0 : 5'd17;
            ddone_reg <= (rd <= start_reg);
        end
        else if (cmd.div_step && dcnt_reg != 5'd0)
        begin
            if (rem_reg >= len_reg)
            begin
                rem_reg <= (rem_reg - len_reg) << 1;
                w_reg <= {w_reg[15:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_reg << 1;
                w_reg <= {w_reg[15:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg - 1'b1;
            ddone_reg <= (dcnt_reg == 5'd1);
        end
        if (cmd.load_query)
        begin
            dcnt_reg <= '0;
            ddone_reg <= 1'b0;
            w_reg <= '0;
        end
    end

    // Interpolation: p0 + floor((p1-p0)*w/65536).
    logic signed [32:0] dx, dy;
    logic signed [50:0] mx, my;
    logic [16:0] w_use;
    assign w_use = (first_reg || last_reg) ? 17'd0 : w_reg;
    assign dx = 33'(signed'(rx)) - 33'(signed'(x0_reg));
    assign dy = 33'(signed'(ry)) - 33'(signed'(y0_reg));
    assign mx = 51'(dx) * 51'(signed'({1'b0, w_use}));
    assign my = 51'(dy) * 51'(signed'({1'b0, w_use}));

    always_ff @(posedge clk)
    begin
        if (cmd.take_p0)
        begin
            x0_reg <= rx;
            y0_reg <= ry;
        end
        if (cmd.take_p1)
        begin
            if (first_reg || last_reg)
            begin
                ox_reg <= x0_reg;
                oy_reg <= y0_reg;
            end
        end
        if (cmd.lerp)
        begin
            ox_reg <= (first_reg || last_reg) ? x0_reg : x0_reg + 32'(mx >>> 16);
            oy_reg <= (first_reg || last_reg) ? y0_reg : y0_reg + 32'(my >>> 16);
        end
    end

    assign res_x = (inv_reg || empty_reg) ? 32'd0 : ox_reg;
    assign res_y = (inv_reg || empty_reg) ? 32'd0 : oy_reg;
    assign res_vis = !inv_reg;

    assign status.invisible = inv_reg;
    assign status.empty = empty_reg;
    assign status.first_only = (n_reg < 2) || (total_length == 0) || (t_reg <= 0)
                               || (prod[63:16] == '0);
    assign status.use_last = !status.first_only
                             && (prod[63:16] >= {16'd0, total_length});
    assign status.search_done = !(lo_reg < hi_reg);
    assign status.div_done = ddone_reg;

endmodule

@@ sv/polyline_arc_length_point.sv @@
// Top level of the polyline arc length point block.
// Depends on pal_pkg, pal_ctrl and pal_dp.
// Usage:
// Input channel in_valid/in_stall carries one item: command selects a table
// write (vertex and cumulative distance at entry_index, no result) or a query
// with fraction query_t. Each query yields one result on out_valid/out_stall:
// pos_x, pos_y and visible. Registers point_count, total_length and
// min_render_pos are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while idle; the block itself does not enforce this. Writes
// can follow each other with no gap. A hidden query or an empty table goes
// straight to the output register; a first or last vertex is read and passed
// on; for a searched segment a binary search (one memory read and one compare
// per step, ten steps for a full table) is followed by a restoring divide, two
// vertex reads and interpolation. One item is worked on at a time; in_stall
// is high while a query runs, and the next item is taken in the cycle after
// the result is loaded. A finished result waits in the output register while
// out_stall is high; a following query then holds in its last step until the
// register frees. Reset clears the configuration registers, output valid flag
// and control state; table contents are undefined until written.
`timescale 1ns / 1ps
module polyline_arc_length_point
    import pal_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               command,
    input  logic [9:0]         entry_index,
    input  logic signed [31:0] vertex_x,
    input  logic signed [31:0] vertex_y,
    input  logic [31:0]        end_distance,
    input  logic signed [31:0] query_t,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic               visible,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    logic [CntW-1:0] count_reg;
    logic [31:0] total_reg;
    logic signed [31:0] minr_reg;
    logic valid_reg;
    logic [31:0] x_reg, y_reg;
    logic vis_reg;
    pal_cmd_t cmd;
    pal_status_t status;
    logic busy, in_go, wr_en, out_taken;
    logic [31:0] res_x, res_y;
    logic res_vis;

    assign in_stall = busy;
    assign in_go = in_valid && !busy && (command == CmdQuery);
    assign wr_en = in_valid && !busy && (command == CmdWrite);
    assign out_taken = valid_reg && !out_stall;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            total_reg <= '0;
            minr_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                RegPointCount:  count_reg <= cfg_data[CntW-1:0];
                RegTotalLength: total_reg <= cfg_data;
                RegMinRender:   minr_reg <= signed'(cfg_data);
                default: ;
            endcase
        end
    end

    pal_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_go(in_go), .out_valid(valid_reg),
        .out_taken(out_taken), .status(status), .cmd(cmd), .busy(busy));

    pal_dp u_dp (
        .clk(clk), .wr_en(wr_en), .wr_idx(entry_index),
        .wr_x(vertex_x), .wr_y(vertex_y), .wr_d(end_distance), .q_t(query_t),
        .point_count(count_reg), .total_length(total_reg), .min_render(minr_reg),
        .cmd(cmd), .status(status), .res_x(res_x), .res_y(res_y), .res_vis(res_vis));

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_taken)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            x_reg <= res_x;
            y_reg <= res_y;
            vis_reg <= res_vis;
        end
    end

    assign out_valid = valid_reg;
    assign pos_x = signed'(x_reg);
    assign pos_y = signed'(y_reg);
    assign visible = vis_reg;

endmodule
